// ----- hw/rtl/rmq_pkg.sv -----
// shared types, widths and codes for the rotation matrix to quaternion core
package rmq_pkg;

	localparam int FRAC_BITS = 14;
	localparam int ELEM_W    = 16;
	// radicand is one plus up to three elements, signed
	localparam int RAD_W     = ((FRAC_BITS > ELEM_W + 1) ? FRAC_BITS : ELEM_W + 1) + 3;
	localparam int SQ_IN_W   = RAD_W - 1 + FRAC_BITS;
	localparam int Q_W       = (SQ_IN_W + 1) / 2;
	localparam int V_W       = 2 * Q_W;
	localparam int REM_W     = Q_W + 3;
	localparam int D_W       = ELEM_W + 1;
	localparam int DEN_W     = Q_W + 1;
	localparam int NUM_W     = D_W + FRAC_BITS + 1;
	localparam int LANES     = 3;

	typedef enum logic [1:0] {
		CASE_TRACE = 2'd0,
		CASE_X     = 2'd1,
		CASE_Y     = 2'd2,
		CASE_Z     = 2'd3
	} case_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] row0_col0;
		logic signed [ELEM_W-1:0] row0_col1;
		logic signed [ELEM_W-1:0] row0_col2;
		logic signed [ELEM_W-1:0] row1_col0;
		logic signed [ELEM_W-1:0] row1_col1;
		logic signed [ELEM_W-1:0] row1_col2;
		logic signed [ELEM_W-1:0] row2_col0;
		logic signed [ELEM_W-1:0] row2_col1;
		logic signed [ELEM_W-1:0] row2_col2;
	} mat_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] quat_w;
		logic signed [ELEM_W-1:0] quat_x;
		logic signed [ELEM_W-1:0] quat_y;
		logic signed [ELEM_W-1:0] quat_z;
		logic [1:0]               case_taken;
		logic                     bad_input;
	} quat_t;

	// sideband through the root stages: branch, error, three numerators
	typedef struct packed {
		case_t                        sel;
		logic                         bad;
		logic [LANES-1:0][D_W-1:0]    dv;
	} root_side_t;

	// sideband through the divider stages
	typedef struct packed {
		case_t          sel;
		logic           bad;
		logic [Q_W-1:0] root;
	} div_side_t;

endpackage

// ----- hw/rtl/rmq_front.sv -----
// first stage: trace, branch pick, radicand and numerator sums and differences
module rmq_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  rmq_pkg::mat_t                 mat,
	output logic                          vld_s1,
	output rmq_pkg::root_side_t           side_s1,
	output logic [rmq_pkg::V_W-1:0]       sq_s1
);

	logic signed [rmq_pkg::RAD_W-1:0] a00, a11, a22, tr, one, rad;
	logic signed [rmq_pkg::D_W-1:0]   m01, m02, m10, m12, m20, m21;
	rmq_pkg::case_t                   sel;
	logic [rmq_pkg::LANES-1:0][rmq_pkg::D_W-1:0] dv;
	logic [rmq_pkg::V_W-1:0]          sq;

	always_comb begin
		a00 = rmq_pkg::RAD_W'(mat.row0_col0);
		a11 = rmq_pkg::RAD_W'(mat.row1_col1);
		a22 = rmq_pkg::RAD_W'(mat.row2_col2);
		m01 = rmq_pkg::D_W'(mat.row0_col1);
		m02 = rmq_pkg::D_W'(mat.row0_col2);
		m10 = rmq_pkg::D_W'(mat.row1_col0);
		m12 = rmq_pkg::D_W'(mat.row1_col2);
		m20 = rmq_pkg::D_W'(mat.row2_col0);
		m21 = rmq_pkg::D_W'(mat.row2_col1);
		one = '0;
		one[rmq_pkg::FRAC_BITS] = 1'b1;
		tr  = a00 + a11 + a22;
		// ties fall through to the later branch
		if (tr > one) begin
			sel = rmq_pkg::CASE_TRACE;
			rad = tr + one;
			dv  = {m01 - m10, m20 - m02, m12 - m21};
		end else if (a00 > a11 && a00 > a22) begin
			sel = rmq_pkg::CASE_X;
			rad = one + a00 - a11 - a22;
			dv  = {m20 + m02, m01 + m10, m12 - m21};
		end else if (a11 > a22) begin
			sel = rmq_pkg::CASE_Y;
			rad = one - a00 + a11 - a22;
			dv  = {m12 + m21, m01 + m10, m20 - m02};
		end else begin
			sel = rmq_pkg::CASE_Z;
			rad = one - a00 - a11 + a22;
			dv  = {m12 + m21, m20 + m02, m01 - m10};
		end
		sq = rmq_pkg::V_W'(rad[rmq_pkg::RAD_W-2:0]);
		sq = sq << rmq_pkg::FRAC_BITS;
		if (rad <= 0) begin
			sq = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.sel <= sel;
			side_s1.bad <= (rad <= 0);
			side_s1.dv  <= dv;
			sq_s1       <= sq;
		end
	end

endmodule

// ----- hw/rtl/rmq_sqrt.sv -----
// pipelined integer square root, one result bit per stage
module rmq_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  rmq_pkg::root_side_t         in_side,
	input  logic [rmq_pkg::V_W-1:0]     in_sq,
	output logic                        out_valid,
	output rmq_pkg::root_side_t         out_side,
	output logic [rmq_pkg::Q_W-1:0]     out_root
);

	logic                        vld_s  [1:rmq_pkg::Q_W];
	rmq_pkg::root_side_t         side_s [1:rmq_pkg::Q_W];
	logic [rmq_pkg::V_W-1:0]     val_s  [1:rmq_pkg::Q_W];
	logic [rmq_pkg::REM_W-1:0]   rem_s  [1:rmq_pkg::Q_W];
	logic [rmq_pkg::Q_W-1:0]     root_s [1:rmq_pkg::Q_W];

	for (genvar k = 1; k <= rmq_pkg::Q_W; k++) begin : g_stage
		logic                      pv;
		rmq_pkg::root_side_t       pside;
		logic [rmq_pkg::V_W-1:0]   pval;
		logic [rmq_pkg::REM_W-1:0] prem, r2, trial;
		logic [rmq_pkg::Q_W-1:0]   proot;
		logic                      ge;

		if (k == 1) begin : g_first
			assign pv    = in_valid;
			assign pside = in_side;
			assign pval  = in_sq;
			assign prem  = '0;
			assign proot = '0;
		end else begin : g_next
			assign pv    = vld_s[k-1];
			assign pside = side_s[k-1];
			assign pval  = val_s[k-1];
			assign prem  = rem_s[k-1];
			assign proot = root_s[k-1];
		end

		always_comb begin
			r2    = {prem[rmq_pkg::REM_W-3:0], pval[rmq_pkg::V_W-1 -: 2]};
			trial = rmq_pkg::REM_W'({proot, 2'b01});
			ge    = (r2 >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= pside;
				val_s[k]  <= {pval[rmq_pkg::V_W-3:0], 2'b00};
				rem_s[k]  <= ge ? (r2 - trial) : r2;
				root_s[k] <= {proot[rmq_pkg::Q_W-2:0], ge};
			end
		end
	end

	assign out_valid = vld_s[rmq_pkg::Q_W];
	assign out_side  = side_s[rmq_pkg::Q_W];
	assign out_root  = root_s[rmq_pkg::Q_W];

endmodule

// ----- hw/rtl/rmq_div.sv -----
// three-lane pipelined restoring divider, numerator scaled and rounded
module rmq_div (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      en,
	input  logic                                      in_valid,
	input  rmq_pkg::root_side_t                       in_side,
	input  logic [rmq_pkg::Q_W-1:0]                   in_root,
	output logic                                      out_valid,
	output rmq_pkg::div_side_t                        out_side,
	output logic [rmq_pkg::LANES-1:0][rmq_pkg::NUM_W-1:0] out_quot,
	output logic [rmq_pkg::LANES-1:0]                 out_neg
);

	localparam int N = rmq_pkg::NUM_W;

	logic                                          vld_s  [1:N];
	rmq_pkg::div_side_t                            side_s [1:N];
	logic [rmq_pkg::LANES-1:0][N-1:0]              num_s  [1:N];
	logic [rmq_pkg::LANES-1:0][rmq_pkg::DEN_W-1:0] rem_s  [1:N];
	logic [rmq_pkg::LANES-1:0]                     neg_s  [1:N];

	rmq_pkg::div_side_t                        side0;
	logic [rmq_pkg::LANES-1:0][N-1:0]          num0;
	logic [rmq_pkg::LANES-1:0]                 neg0;
	logic [rmq_pkg::D_W-1:0]                   mag;

	// numerator = |d| * 2^frac + q, so the quotient by 2q rounds half away
	always_comb begin
		side0.sel  = in_side.sel;
		side0.bad  = in_side.bad;
		side0.root = in_root;
		mag        = '0;
		for (int j = 0; j < rmq_pkg::LANES; j++) begin
			neg0[j] = in_side.dv[j][rmq_pkg::D_W-1];
			mag     = neg0[j] ? (~in_side.dv[j] + 1'b1) : in_side.dv[j];
			num0[j] = (N'(mag) << rmq_pkg::FRAC_BITS) + N'(in_root);
		end
	end

	for (genvar k = 1; k <= N; k++) begin : g_stage
		logic                                          pv;
		rmq_pkg::div_side_t                            pside;
		logic [rmq_pkg::LANES-1:0][N-1:0]              pnum, nnum;
		logic [rmq_pkg::LANES-1:0][rmq_pkg::DEN_W-1:0] prem, nrem;
		logic [rmq_pkg::LANES-1:0]                     pneg;
		logic [rmq_pkg::DEN_W-1:0]                     den;
		logic [rmq_pkg::DEN_W:0]                       r2;

		if (k == 1) begin : g_first
			assign pv    = in_valid;
			assign pside = side0;
			assign pnum  = num0;
			assign prem  = '0;
			assign pneg  = neg0;
		end else begin : g_next
			assign pv    = vld_s[k-1];
			assign pside = side_s[k-1];
			assign pnum  = num_s[k-1];
			assign prem  = rem_s[k-1];
			assign pneg  = neg_s[k-1];
		end

		always_comb begin
			den = {pside.root, 1'b0};
			r2  = '0;
			for (int j = 0; j < rmq_pkg::LANES; j++) begin
				r2 = {prem[j], pnum[j][N-1]};
				if (r2 >= {1'b0, den}) begin
					nrem[j] = rmq_pkg::DEN_W'(r2 - {1'b0, den});
					nnum[j] = {pnum[j][N-2:0], 1'b1};
				end else begin
					nrem[j] = rmq_pkg::DEN_W'(r2);
					nnum[j] = {pnum[j][N-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= pside;
				num_s[k]  <= nnum;
				rem_s[k]  <= nrem;
				neg_s[k]  <= pneg;
			end
		end
	end

	assign out_valid = vld_s[N];
	assign out_side  = side_s[N];
	assign out_quot  = num_s[N];
	assign out_neg   = neg_s[N];

endmodule

// ----- hw/rtl/rotation_matrix_to_quaternion_core.sv -----
// top level: rotation matrix to quaternion pipeline with output register
//
//   channel  | signals                         | direction | payload
//   ---------+---------------------------------+-----------+-------------------
//   matrix   | mat_valid, mat_ready, mat       | in        | nine Q1.14 elements
//   result   | quat_valid, quat_ready, quat    | out       | w x y z, case, error
//
// one matrix enters per cycle while the result is not stalled; the stages are the
// front stage, one root bit per stage, one quotient bit per divider
// stage, then the saturating output register.
// a stalled result freezes the whole pipeline; nothing is lost or repeated.
// reset clears only the valid bits; data registers carry no reset.
module rotation_matrix_to_quaternion_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           mat_valid,
	output logic           mat_ready,
	input  rmq_pkg::mat_t  mat,
	output logic           quat_valid,
	input  logic           quat_ready,
	output rmq_pkg::quat_t quat
);

	logic                                          en;
	logic                                          vld_s1;
	rmq_pkg::root_side_t                           side_s1;
	logic [rmq_pkg::V_W-1:0]                       sq_s1;
	logic                                          sqrt_vld;
	rmq_pkg::root_side_t                           sqrt_side;
	logic [rmq_pkg::Q_W-1:0]                       sqrt_root;
	logic                                          div_vld;
	rmq_pkg::div_side_t                            div_side;
	logic [rmq_pkg::LANES-1:0][rmq_pkg::NUM_W-1:0] div_quot;
	logic [rmq_pkg::LANES-1:0]                     div_neg;
	logic signed [rmq_pkg::ELEM_W-1:0]             big;
	logic signed [rmq_pkg::ELEM_W-1:0]             l0, l1, l2;
	logic [rmq_pkg::Q_W:0]                         half;
	rmq_pkg::quat_t                                quat_nxt;
	logic                                          vld_q;
	rmq_pkg::quat_t                                quat_q;

	// saturate a signed magnitude pair to 16 bits
	function automatic logic signed [rmq_pkg::ELEM_W-1:0] sat_lane(
		input logic neg, input logic [rmq_pkg::NUM_W-1:0] mag);
		logic signed [rmq_pkg::ELEM_W-1:0] r;
		if (!neg) begin
			r = (mag > rmq_pkg::NUM_W'(32767)) ? 16'sh7fff : rmq_pkg::ELEM_W'(mag);
		end else begin
			r = (mag > rmq_pkg::NUM_W'(32768)) ? 16'sh8000
				: (~rmq_pkg::ELEM_W'(mag) + 16'sd1);
		end
		return r;
	endfunction

	// pipeline advances whenever the output register is free or being taken
	assign en        = !vld_q || quat_ready;
	assign mat_ready = en;

	rmq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (mat_valid),
		.mat      (mat),
		.vld_s1   (vld_s1),
		.side_s1  (side_s1),
		.sq_s1    (sq_s1)
	);

	rmq_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s1),
		.in_side   (side_s1),
		.in_sq     (sq_s1),
		.out_valid (sqrt_vld),
		.out_side  (sqrt_side),
		.out_root  (sqrt_root)
	);

	rmq_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sqrt_vld),
		.in_side   (sqrt_side),
		.in_root   (sqrt_root),
		.out_valid (div_vld),
		.out_side  (div_side),
		.out_quot  (div_quot),
		.out_neg   (div_neg)
	);

	// large component is half the root rounded half up; lanes fill the others
	always_comb begin
		half = ({1'b0, div_side.root} + 1'b1) >> 1;
		big  = (half > (rmq_pkg::Q_W + 1)'(32767)) ? 16'sh7fff : rmq_pkg::ELEM_W'(half);
		l0   = sat_lane(div_neg[0], div_quot[0]);
		l1   = sat_lane(div_neg[1], div_quot[1]);
		l2   = sat_lane(div_neg[2], div_quot[2]);
		quat_nxt.case_taken = div_side.sel;
		quat_nxt.bad_input  = div_side.bad;
		unique case (div_side.sel)
			rmq_pkg::CASE_TRACE: begin
				quat_nxt.quat_w = big; quat_nxt.quat_x = l0;
				quat_nxt.quat_y = l1;  quat_nxt.quat_z = l2;
			end
			rmq_pkg::CASE_X: begin
				quat_nxt.quat_w = l0;  quat_nxt.quat_x = big;
				quat_nxt.quat_y = l1;  quat_nxt.quat_z = l2;
			end
			rmq_pkg::CASE_Y: begin
				quat_nxt.quat_w = l0;  quat_nxt.quat_x = l1;
				quat_nxt.quat_y = big; quat_nxt.quat_z = l2;
			end
			default: begin
				quat_nxt.quat_w = l0;  quat_nxt.quat_x = l1;
				quat_nxt.quat_y = l2;  quat_nxt.quat_z = big;
			end
		endcase
		// not-positive radicand zeroes the quaternion, branch still reported
		if (div_side.bad) begin
			quat_nxt.quat_w = '0;
			quat_nxt.quat_x = '0;
			quat_nxt.quat_y = '0;
			quat_nxt.quat_z = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quat_q <= quat_nxt;
		end
	end

	assign quat_valid = vld_q;
	assign quat       = quat_q;

endmodule

// ----- hw/rtl/rmq_checker.sv -----
// port-level checks for the rotation matrix to quaternion core, with bind
module rmq_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           mat_valid,
	input logic           mat_ready,
	input rmq_pkg::mat_t  mat,
	input logic           quat_valid,
	input logic           quat_ready,
	input rmq_pkg::quat_t quat
);

	// a waiting matrix stays put until its transfer
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mat_valid && !mat_ready |=> mat_valid && $stable(mat))
		else $error("matrix changed while waiting");

	// a held result stays put until its transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		quat_valid && !quat_ready |=> quat_valid && $stable(quat))
		else $error("result changed while stalled");

	// matrix side takes data exactly when the output slot frees up
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		mat_ready == (!quat_valid || quat_ready))
		else $error("matrix ready does not follow output slot");

	// error results carry an all-zero quaternion
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		quat_valid && quat.bad_input |->
			quat.quat_w == 0 && quat.quat_x == 0 && quat.quat_y == 0 && quat.quat_z == 0)
		else $error("error result with nonzero quaternion");

	// the component picked by the branch is strictly positive
	a_big_pos: assert property (@(posedge clk) disable iff (!arst_n)
		quat_valid && !quat.bad_input |->
			(quat.case_taken == rmq_pkg::CASE_TRACE && quat.quat_w > 0) ||
			(quat.case_taken == rmq_pkg::CASE_X && quat.quat_x > 0) ||
			(quat.case_taken == rmq_pkg::CASE_Y && quat.quat_y > 0) ||
			(quat.case_taken == rmq_pkg::CASE_Z && quat.quat_z > 0))
		else $error("branch component not positive");

endmodule

bind rotation_matrix_to_quaternion_core rmq_checker u_rmq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.mat_valid  (mat_valid),
	.mat_ready  (mat_ready),
	.mat        (mat),
	.quat_valid (quat_valid),
	.quat_ready (quat_ready),
	.quat       (quat)
);
